/* rtl/core/asd_pkg.sv */
// Package for the APID sample demultiplexer.
// Holds the request and result structs, the packet type tables and shared constants.
// No dependencies.
`timescale 1ns / 1ps

package asd_pkg;

    typedef struct packed {
        logic        first_byte;
        logic [10:0] packet_id;
        logic [15:0] payload_length;
        logic [7:0]  data_byte;
    } in_t;

    typedef struct packed {
        logic [4:0]  channel;
        logic [15:0] line_number;
        logic [10:0] sample_index;
        logic [15:0] sample;
        logic        end_of_line;
    } out_t;

    typedef struct packed {
        logic       inc;
        logic [4:0] channel;
    } cnt_req_t;

    localparam int unsigned CHANNEL_COUNT = 24;

    localparam logic [10:0] FIRST_APID   = 11'd1105;
    localparam logic [10:0] LAST_APID    = 11'd1111;
    localparam logic [15:0] SAMPLE_START = 16'd28;
    localparam logic [15:0] POS_MAX      = 16'hFFFF;
    localparam logic [15:0] SAMPLE_FLIP  = 16'h8000;

    localparam logic [4:0] SLOT_BASE [0:7] = '{
        5'd0, 5'd1, 5'd2, 5'd16, 5'd17, 5'd18, 5'd23, 5'd0
    };
    localparam logic [3:0] SLOT_LINES [0:7] = '{
        4'd1, 4'd1, 4'd14, 4'd1, 4'd1, 4'd5, 4'd1, 4'd0
    };
    localparam logic [10:0] SLOT_LENGTH [0:7] = '{
        11'd1680, 11'd1680, 11'd105, 11'd105, 11'd105, 11'd105, 11'd105, 11'd105
    };
    localparam logic [15:0] SLOT_MIN_PAYLOAD [0:7] = '{
        16'd3388, 16'd3388, 16'd2968, 16'd238, 16'd238, 16'd1078, 16'd238, 16'hFFFF
    };

endpackage

/* rtl/core/apid_sample_demultiplexer.sv */
// Top level of the APID sample demultiplexer.
// Decodes packet type, assembles 16-bit samples and tags them with channel and line.
// Depends on asd_pkg and asd_line_counters.
//
// Usage: payload bytes enter on the s_ channel, one request per byte, with the
// packet's APID and payload length; first_byte marks payload byte 0. Accepted
// packets of types 1105 to 1111 feed 24 channels. Every second byte of the
// sample area, starting at payload byte 28, completes a big-endian word, and a
// result leaves on the m_ channel with bit 15 of the word inverted, the
// channel, its line number, the index in the line and an end-of-line flag.
// A result is registered: it is valid in the cycle after its byte is
// accepted. Throughput is one byte per cycle while the receiver does not stall, set by
// the single output register, which is refilled in the same cycle it is taken.
// When the receiver stalls with a result waiting, s_ready drops until that
// result is taken. Reset clears the packet state, the output valid and all
// 24 line counters; the block is ready as soon as reset is released.
`timescale 1ns / 1ps

module apid_sample_demultiplexer #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  asd_pkg::in_t  s_data,
    output logic          m_valid,
    input  logic          m_ready,
    output asd_pkg::out_t m_data
);

    logic [15:0] byte_position_reg, byte_position_next;
    logic [7:0]  held_high_byte_reg, held_high_byte_next;
    logic        packet_accepted_reg, packet_accepted_next;
    logic [2:0]  packet_slot_reg, packet_slot_next;
    logic [3:0]  channel_offset_reg, channel_offset_next;
    logic [10:0] sample_counter_reg, sample_counter_next;
    logic        m_valid_reg, m_valid_next;
    asd_pkg::out_t out_reg, out_next;

    logic        accept;
    logic [15:0] pos;
    logic        cur_accepted;
    logic [2:0]  cur_slot;
    logic [3:0]  cur_offset;
    logic [10:0] cur_counter;
    logic [7:0]  cur_held;
    logic        apid_known;
    logic        active;
    logic        emit;
    logic [4:0]  ch;
    logic [10:0] counter_inc;
    logic        eol;
    asd_pkg::cnt_req_t cnt_req;
    logic [LINE_COUNT_BITS-1:0] rd_count;

    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

    assign apid_known = (s_data.packet_id >= asd_pkg::FIRST_APID)
                     && (s_data.packet_id <= asd_pkg::LAST_APID);

    always_comb begin
        if (s_data.first_byte) begin
            pos          = '0;
            cur_slot     = apid_known ? 3'(s_data.packet_id - asd_pkg::FIRST_APID) : 3'd0;
            cur_accepted = apid_known
                        && (s_data.payload_length >= asd_pkg::SLOT_MIN_PAYLOAD[cur_slot]);
            cur_offset   = '0;
            cur_counter  = '0;
            cur_held     = '0;
        end else begin
            pos          = byte_position_reg;
            cur_slot     = packet_slot_reg;
            cur_accepted = packet_accepted_reg;
            cur_offset   = channel_offset_reg;
            cur_counter  = sample_counter_reg;
            cur_held     = held_high_byte_reg;
        end
    end

    assign active = cur_accepted && (pos >= asd_pkg::SAMPLE_START)
                 && (cur_offset < asd_pkg::SLOT_LINES[cur_slot]);
    assign ch     = asd_pkg::SLOT_BASE[cur_slot] + 5'(cur_offset);
    assign emit   = active && pos[0] && (ch < 5'(asd_pkg::CHANNEL_COUNT));
    assign counter_inc = cur_counter + 11'd1;
    assign eol    = (counter_inc >= asd_pkg::SLOT_LENGTH[cur_slot]);

    assign cnt_req.inc     = accept && emit && eol;
    assign cnt_req.channel = ch;

    asd_line_counters #(
        .LINE_COUNT_BITS(LINE_COUNT_BITS)
    ) u_line_counters (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (cnt_req),
        .rd_count (rd_count)
    );

    always_comb begin
        byte_position_next   = byte_position_reg;
        held_high_byte_next  = held_high_byte_reg;
        packet_accepted_next = packet_accepted_reg;
        packet_slot_next     = packet_slot_reg;
        channel_offset_next  = channel_offset_reg;
        sample_counter_next  = sample_counter_reg;
        m_valid_next         = m_valid_reg && !m_ready;
        out_next             = out_reg;
        if (accept) begin
            byte_position_next   = (pos < asd_pkg::POS_MAX) ? pos + 16'd1 : asd_pkg::POS_MAX;
            packet_accepted_next = cur_accepted;
            packet_slot_next     = cur_slot;
            channel_offset_next  = cur_offset;
            sample_counter_next  = cur_counter;
            held_high_byte_next  = cur_held;
            if (active && !pos[0]) begin
                held_high_byte_next = s_data.data_byte;
            end
            if (emit) begin
                m_valid_next         = 1'b1;
                out_next.channel     = ch;
                out_next.line_number = 16'(rd_count);
                out_next.sample_index = cur_counter;
                out_next.sample      = {cur_held, s_data.data_byte} ^ asd_pkg::SAMPLE_FLIP;
                out_next.end_of_line = eol;
                if (eol) begin
                    sample_counter_next = '0;
                    channel_offset_next = cur_offset + 4'd1;
                end else begin
                    sample_counter_next = counter_inc;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            byte_position_reg   <= '0;
            held_high_byte_reg  <= '0;
            packet_accepted_reg <= 1'b0;
            packet_slot_reg     <= '0;
            channel_offset_reg  <= '0;
            sample_counter_reg  <= '0;
            m_valid_reg         <= 1'b0;
        end else begin
            byte_position_reg   <= byte_position_next;
            held_high_byte_reg  <= held_high_byte_next;
            packet_accepted_reg <= packet_accepted_next;
            packet_slot_reg     <= packet_slot_next;
            channel_offset_reg  <= channel_offset_next;
            sample_counter_reg  <= sample_counter_next;
            m_valid_reg         <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_reg <= out_next;
    end

`ifndef NO_ASSERTIONS
    a_no_accept_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_ready) |-> !accept)
        else $error("request accepted while a result was stalled");

    a_result_ranges: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (out_reg.channel < 5'd24) && (out_reg.sample_index < 11'd1680))
        else $error("result channel or sample index out of range");

    a_eol_position: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.end_of_line) |->
            (out_reg.sample_index == 11'd104) || (out_reg.sample_index == 11'd1679))
        else $error("end of line at an unexpected sample index");

    a_wide_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && out_reg.end_of_line && (out_reg.channel < 5'd2)) |->
            (out_reg.sample_index == 11'd1679))
        else $error("short line on a wide channel");
`endif

endmodule

/* rtl/core/asd_line_counters.sv */
// Per-channel saturating line counters for the APID sample demultiplexer.
// One read and one increment per cycle at the channel given by the request.
// Depends on asd_pkg.
`timescale 1ns / 1ps

module asd_line_counters #(
    parameter int LINE_COUNT_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  asd_pkg::cnt_req_t          req,
    output logic [LINE_COUNT_BITS-1:0] rd_count
);

    logic [LINE_COUNT_BITS-1:0] cnt_reg [0:asd_pkg::CHANNEL_COUNT-1];
    logic                       in_range;

    assign in_range = (req.channel < 5'(asd_pkg::CHANNEL_COUNT));
    assign rd_count = in_range ? cnt_reg[req.channel] : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < asd_pkg::CHANNEL_COUNT; i++) begin
                cnt_reg[i] <= '0;
            end
        end else if (req.inc && in_range) begin
            if (cnt_reg[req.channel] != {LINE_COUNT_BITS{1'b1}}) begin
                cnt_reg[req.channel] <= cnt_reg[req.channel] + LINE_COUNT_BITS'(1);
            end
        end
    end

endmodule

/* test/tb.sv */
// Self-checking testbench for apid_sample_demultiplexer.
// Random packet streams go in with random idling, and every result is checked against
// a predictor held in a scoreboard class. Depends on asd_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;

    localparam logic [10:0] APID_WIDE_0    = 11'd1105;
    localparam logic [10:0] APID_WIDE_1    = 11'd1106;
    localparam logic [10:0] APID_BAND_14   = 11'd1107;
    localparam logic [10:0] APID_SINGLE_16 = 11'd1108;
    localparam logic [10:0] APID_SINGLE_17 = 11'd1109;
    localparam logic [10:0] APID_BAND_5    = 11'd1110;
    localparam logic [10:0] APID_SINGLE_23 = 11'd1111;
    localparam logic [15:0] SAMPLE_OFFSET  = 16'd28;
    localparam logic [15:0] COUNT_MAX      = 16'hFFFF;
    localparam logic [15:0] TOP_BIT        = 16'h8000;
    localparam logic [10:0] WIDE_LINE      = 11'd1680;
    localparam int          MAX_REPORTS    = 10;

    logic          aclk;
    logic          aresetn;
    logic          s_valid;
    logic          s_ready;
    asd_pkg::in_t  s_data;
    logic          m_valid;
    logic          m_ready;
    asd_pkg::out_t m_data;

    apid_sample_demultiplexer dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    class sample_scoreboard;
        asd_pkg::out_t expected_samples[$];
        int            failures;
        logic [15:0]   byte_pos;
        logic [7:0]    high_byte;
        bit            accepted;
        logic [4:0]    base_channel;
        logic [3:0]    line_total;
        logic [10:0]   line_length;
        logic [3:0]    line_in_packet;
        logic [10:0]   sample_count;
        logic [15:0]   line_count [asd_pkg::CHANNEL_COUNT];

        function new();
            failures = 0;
            byte_pos = '0;
            high_byte = '0;
            accepted = 1'b0;
            base_channel = '0;
            line_total = '0;
            line_length = '0;
            line_in_packet = '0;
            sample_count = '0;
            for (int c = 0; c < asd_pkg::CHANNEL_COUNT; c++) begin
                line_count[c] = '0;
            end
        endfunction

        function bit packet_shape(input logic [10:0] apid, output logic [4:0] base,
                                  output logic [3:0] lines, output logic [10:0] len,
                                  output logic [15:0] min_len);
            bit known;
            known = 1'b1;
            base = '0;
            lines = 4'd1;
            len = 11'd105;
            min_len = 16'd238;
            case (apid)
                APID_WIDE_0: begin
                    len = WIDE_LINE;
                    min_len = 16'd3388;
                end
                APID_WIDE_1: begin
                    base = 5'd1;
                    len = WIDE_LINE;
                    min_len = 16'd3388;
                end
                APID_BAND_14: begin
                    base = 5'd2;
                    lines = 4'd14;
                    min_len = 16'd2968;
                end
                APID_SINGLE_16: base = 5'd16;
                APID_SINGLE_17: base = 5'd17;
                APID_BAND_5: begin
                    base = 5'd18;
                    lines = 4'd5;
                    min_len = 16'd1078;
                end
                APID_SINGLE_23: base = 5'd23;
                default: known = 1'b0;
            endcase
            return known;
        endfunction

        function void note_byte(asd_pkg::in_t req);
            logic [15:0]   pos;
            logic [15:0]   rel;
            logic [15:0]   min_len;
            logic [4:0]    ch;
            asd_pkg::out_t want;
            if (req.first_byte) begin
                pos = '0;
                accepted = 1'b0;
                line_in_packet = '0;
                sample_count = '0;
                high_byte = '0;
                if (packet_shape(req.packet_id, base_channel, line_total, line_length, min_len))
                    accepted = (req.payload_length >= min_len);
            end else begin
                pos = byte_pos;
            end
            byte_pos = (pos == COUNT_MAX) ? pos : pos + 16'd1;
            if (!accepted || pos < SAMPLE_OFFSET || line_in_packet >= line_total) return;
            rel = pos - SAMPLE_OFFSET;
            if (!rel[0]) begin
                high_byte = req.data_byte;
                return;
            end
            ch = base_channel + 5'(line_in_packet);
            want.channel = ch;
            want.line_number = line_count[ch];
            want.sample_index = sample_count;
            want.sample = {high_byte, req.data_byte} ^ TOP_BIT;
            want.end_of_line = 1'b0;
            sample_count = sample_count + 11'd1;
            if (sample_count >= line_length) begin
                want.end_of_line = 1'b1;
                sample_count = '0;
                line_in_packet = line_in_packet + 4'd1;
                if (line_count[ch] != COUNT_MAX) line_count[ch] = line_count[ch] + 16'd1;
            end
            expected_samples.insert(expected_samples.size(), want);
        endfunction

        function void report(string what, asd_pkg::out_t want, asd_pkg::out_t got);
            failures++;
            if (failures <= MAX_REPORTS) begin
                $display("%0t %s: expected ch=%0d line=%0d idx=%0d sample=%h eol=%0b",
                         $time, what, want.channel, want.line_number, want.sample_index,
                         want.sample, want.end_of_line);
                $display("    got ch=%0d line=%0d idx=%0d sample=%h eol=%0b",
                         got.channel, got.line_number, got.sample_index, got.sample,
                         got.end_of_line);
            end
        endfunction

        function void check_sample(asd_pkg::out_t got);
            asd_pkg::out_t want;
            if (expected_samples.size() == 0) begin
                report("unexpected sample", '0, got);
                return;
            end
            want = expected_samples.pop_front();
            if (got.channel !== want.channel || got.line_number !== want.line_number ||
                got.sample_index !== want.sample_index || got.sample !== want.sample ||
                got.end_of_line !== want.end_of_line)
                report("sample mismatch", want, got);
        endfunction
    endclass

    sample_scoreboard sb = new();
    bit send_steady = 1'b0;
    bit take_steady = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #30_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) sb.note_byte(s_data);
        if (aresetn && m_valid && m_ready) sb.check_sample(m_data);
    end

    function automatic int pause_length(inout bit steady);
        if ($urandom_range(0, 47) == 0) steady = !steady;
        return steady ? 0 : $urandom_range(0, 11);
    endfunction

    task automatic send_request(input asd_pkg::in_t req);
        int gap;
        gap = pause_length(send_steady);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_data <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!(s_valid && s_ready));
    endtask

    // A packet that does not open with a first byte just continues whatever came before.
    task automatic send_packet(input logic [10:0] apid, input logic [15:0] length,
                               input int count, input bit opens);
        asd_pkg::in_t req;
        for (int i = 0; i < count; i++) begin
            req.first_byte = opens && (i == 0);
            req.packet_id = (req.first_byte || $urandom_range(0, 1)) ? apid : 11'($urandom);
            req.payload_length = (req.first_byte || $urandom_range(0, 1)) ?
                                 length : 16'($urandom);
            req.data_byte = 8'($urandom);
            send_request(req);
        end
    endtask

    initial begin : receiver
        int wait_cycles;
        int taken;
        taken = 0;
        m_ready <= 1'b0;
        do @(posedge aclk); while (aresetn !== 1'b1);
        forever begin
            wait_cycles = pause_length(take_steady);
            if (taken == 40 || taken == 400) wait_cycles = 300;
            if (wait_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (wait_cycles) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!(m_valid && m_ready));
            taken++;
        end
    end

    initial begin : stimulus
        int          packet_items;
        int          pick;
        int          count;
        bit          full;
        bit          wide_done;
        bit          band_done;
        logic [10:0] apid;
        logic [15:0] length;
        logic [4:0]  base;
        logic [3:0]  lines;
        logic [10:0] len;
        logic [15:0] min_len;
        packet_items = 0;
        wide_done = 1'b0;
        band_done = 1'b0;
        aresetn <= 1'b0;
        s_valid <= 1'b0;
        s_data <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        send_packet(APID_WIDE_0, COUNT_MAX, 3, 1'b0);
        send_packet(11'h7FF, COUNT_MAX, 2, 1'b1);
        send_packet(11'h000, 16'h0000, 2, 1'b1);
        send_packet(APID_WIDE_0 - 11'd1, COUNT_MAX, 1, 1'b1);
        send_packet(APID_SINGLE_23 + 11'd1, COUNT_MAX, 1, 1'b1);
        send_packet(APID_SINGLE_16, 16'd237, 2, 1'b1);
        for (int a = APID_WIDE_0; a <= APID_SINGLE_23; a++) begin
            void'(sb.packet_shape(11'(a), base, lines, len, min_len));
            send_packet(11'(a), min_len, 1, 1'b1);
        end
        send_packet(APID_BAND_14, 16'd2967, 2, 1'b1);

        while (packet_items < 1000 || !wide_done || !band_done) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                send_packet('0, '0, $urandom_range(1, 20), 1'b0);
            end else if (pick < 16) begin
                do apid = 11'($urandom); while (sb.packet_shape(apid, base, lines, len, min_len));
                send_packet(apid, 16'($urandom), $urandom_range(1, 300), 1'b1);
            end else begin
                apid = APID_WIDE_0 + 11'($urandom_range(0, 6));
                void'(sb.packet_shape(apid, base, lines, len, min_len));
                if (pick < 24) begin
                    send_packet(apid, 16'($urandom_range(0, min_len - 1)),
                                $urandom_range(28, 300), 1'b1);
                end else begin
                    pick = $urandom_range(0, 9);
                    length = (pick < 3) ? min_len :
                             (pick < 5) ? COUNT_MAX : 16'($urandom_range(min_len, 65535));
                    if (lines == 1 && len != WIDE_LINE)
                        full = ($urandom_range(0, 9) < 6);
                    else if (lines == 1)
                        full = !wide_done && ($urandom_range(0, 2) == 0);
                    else
                        full = !band_done && ($urandom_range(0, 2) == 0);
                    if (full) begin
                        count = int'(SAMPLE_OFFSET) + 2 * lines * len + $urandom_range(0, 12);
                        if (lines == 1 && len == WIDE_LINE) wide_done = 1'b1;
                        if (lines > 1) band_done = 1'b1;
                    end else begin
                        count = $urandom_range(1, (lines == 1 && len != WIDE_LINE) ? 237 : 400);
                    end
                    send_packet(apid, length, count, 1'b1);
                    packet_items += count;
                end
            end
        end
        s_valid <= 1'b0;

        while (sb.expected_samples.size() != 0) @(posedge aclk);
        repeat (10) @(posedge aclk);
        if (sb.failures == 0 && sb.expected_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
